>>> src/tfg_pkg.sv
// Shared constants, widths and the CORDIC angle table for triangle facet geometry.
`default_nettype none
package tfg_pkg;

   localparam int SQRT_LEN_W   = 32;   // root bits of the cross-product length
   localparam int SQRT_XY_W    = 31;   // root bits of the horizontal normal length
   localparam int DIV_STEPS    = 31;   // quotient bits of each normal component
   localparam int CORDIC_STEPS = 29;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
   localparam int CORDIC_W     = 36;
   localparam int ANGLE_W      = 33;

   localparam logic signed [ANGLE_W-1:0] PI_Q28      = 33'sd843314857;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q28 = 33'sd421657428;
   localparam logic signed [ANGLE_W-1:0] TWO_PI_Q28  = 33'sd1686629713;
   localparam logic [47:0]               AREA_MAX    = 48'hFFFF_FFFF_FFFF;
   // ceil(2^36 / 3): exact floor division by three for operands below 2^35
   localparam logic [34:0]               RECIP3      = 35'd22906492246;

   // atan(2^-i) in Q3.28, rounded to nearest
   function automatic logic signed [ANGLE_W-1:0] atan_q28(input int idx);
      logic signed [ANGLE_W-1:0] a;
      begin
         case (idx)
            0:  a = 33'sd210828714;
            1:  a = 33'sd124459457;
            2:  a = 33'sd65760959;
            3:  a = 33'sd33381290;
            4:  a = 33'sd16755422;
            5:  a = 33'sd8385879;
            6:  a = 33'sd4193963;
            7:  a = 33'sd2097109;
            8:  a = 33'sd1048571;
            9:  a = 33'sd524287;
            10: a = 33'sd262144;
            11: a = 33'sd131072;
            12: a = 33'sd65536;
            13: a = 33'sd32768;
            14: a = 33'sd16384;
            15: a = 33'sd8192;
            16: a = 33'sd4096;
            17: a = 33'sd2048;
            18: a = 33'sd1024;
            19: a = 33'sd512;
            20: a = 33'sd256;
            21: a = 33'sd128;
            22: a = 33'sd64;
            23: a = 33'sd32;
            24: a = 33'sd16;
            25: a = 33'sd8;
            26: a = 33'sd4;
            27: a = 33'sd2;
            28: a = 33'sd1;
            default: a = 33'sd0;
         endcase
         return a;
      end
   endfunction

endpackage
`default_nettype wire

>>> src/tfg_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none
module tfg_isqrt #(
   parameter int IN_W   = 64,
   parameter int ROOT_W = 32
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [IN_W-1:0]   value,
   output logic      [ROOT_W-1:0] root
);

   logic [IN_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam int B = ROOT_W - 1 - k;
      logic [IN_W-1:0]   rem_prev, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [IN_W+1:0]   trial;

      if (k == 0) begin : g_first
         assign rem_prev  = value;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // trial = 2*root*2^B + 2^(2B)
      always_comb begin
         trial           = (IN_W+2)'(root_prev) << (B + 1);
         trial[2*B]      = 1'b1;
         rem_in          = rem_prev;
         root_in         = root_prev;
         if ((IN_W+2)'(rem_prev) >= trial) begin
            rem_in     = IN_W'((IN_W+2)'(rem_prev) - trial);
            root_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

>>> src/tfg_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q3.28, axis cases exact.
`default_nettype none
module tfg_cordic (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [31:0]                 y_in,
   input  wire logic signed [31:0]                 x_in,
   output logic signed      [tfg_pkg::ANGLE_W-1:0] angle
);
   import tfg_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [CORDIC_LAT];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_LAT];
   logic signed [ANGLE_W-1:0]  z_ff [CORDIC_LAT];
   logic [CORDIC_LAT-1:0]      hold_ff;

   logic signed [CORDIC_W-1:0] x0, y0;
   logic signed [ANGLE_W-1:0]  z0;
   logic                       hold0;

   // axis cases settle the angle at once; left half-plane is pre-rotated by pi
   always_comb begin
      x0    = CORDIC_W'(x_in);
      y0    = CORDIC_W'(y_in);
      z0    = '0;
      hold0 = 1'b0;
      if (y_in == 32'sd0) begin
         hold0 = 1'b1;
         z0    = (x_in < 32'sd0) ? PI_Q28 : '0;
      end else if (x_in == 32'sd0) begin
         hold0 = 1'b1;
         z0    = (y_in > 32'sd0) ? HALF_PI_Q28 : -HALF_PI_Q28;
      end else if (x_in < 32'sd0) begin
         z0 = (y_in > 32'sd0) ? PI_Q28 : -PI_Q28;
         x0 = -x0;
         y0 = -y0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0;
         y_ff[0]    <= y0;
         z_ff[0]    <= z0;
         hold_ff[0] <= hold0;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
      logic signed [CORDIC_W-1:0] dx, dy, x_in_k, y_in_k;
      logic signed [ANGLE_W-1:0]  z_in_k;

      always_comb begin
         dx     = y_ff[k] >>> k;
         dy     = x_ff[k] >>> k;
         x_in_k = x_ff[k];
         y_in_k = y_ff[k];
         z_in_k = z_ff[k];
         if (!hold_ff[k]) begin
            if (y_ff[k] > 0) begin
               x_in_k = x_ff[k] + dx;
               y_in_k = y_ff[k] - dy;
               z_in_k = z_ff[k] + atan_q28(k);
            end else begin
               x_in_k = x_ff[k] - dx;
               y_in_k = y_ff[k] + dy;
               z_in_k = z_ff[k] - atan_q28(k);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]    <= x_in_k;
            y_ff[k+1]    <= y_in_k;
            z_ff[k+1]    <= z_in_k;
            hold_ff[k+1] <= hold_ff[k];
         end
      end
   end

   assign angle = z_ff[CORDIC_LAT-1];

endmodule
`default_nettype wire

>>> src/triangle_facet_geometry.sv
// Top level: triangle centroid, area, outward unit normal and its direction angles.
//
// Usage notes
//   Request channel (req_*): nine signed Q16.16 vertex coordinates, taken at an
//   edge where req_valid is high and req_stall is low. Response channel (rsp_*):
//   centroid, area (Q32.16, saturating), unit normal (Q1.30), elevation and
//   azimuth (Q3.28 rad) and the degenerate flag, one response per request,
//   in request order.
//   From request to rsp_valid the pipe runs through 8 front stages (edges,
//   cross product, block scaling, squared length), 32 stages of length sqrt,
//   1 area stage, 31 stages of restoring division for the three normal
//   components, 4 stages for the centroid dot product and horizontal length,
//   31 stages of sqrt, 30 CORDIC stages and the output register.
//   Throughput is one request per cycle unless stalled; every stage is a
//   register with a valid bit, and nothing is shared between requests.
//   When the receiver holds rsp_stall while a response waits, the whole pipe
//   freezes and req_stall rises; bubbles in flight stay where they are and no
//   request is lost or repeated. Reset clears all valid bits; payload
//   registers are not reset. A degenerate triangle (zero cross product)
//   returns zero normal, area and angles, with the centroid still given.
`default_nettype none
module triangle_facet_geometry (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_vert_a_x,
   input  wire logic signed [31:0] req_vert_a_y,
   input  wire logic signed [31:0] req_vert_a_z,
   input  wire logic signed [31:0] req_vert_b_x,
   input  wire logic signed [31:0] req_vert_b_y,
   input  wire logic signed [31:0] req_vert_b_z,
   input  wire logic signed [31:0] req_vert_c_x,
   input  wire logic signed [31:0] req_vert_c_y,
   input  wire logic signed [31:0] req_vert_c_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed      [31:0] rsp_centre_x,
   output logic signed      [31:0] rsp_centre_y,
   output logic signed      [31:0] rsp_centre_z,
   output logic             [47:0] rsp_facet_area,
   output logic signed      [31:0] rsp_unit_nx,
   output logic signed      [31:0] rsp_unit_ny,
   output logic signed      [31:0] rsp_unit_nz,
   output logic signed      [29:0] rsp_elevation,
   output logic             [30:0] rsp_azimuth,
   output logic                    rsp_degenerate
);
   import tfg_pkg::*;

   localparam int NUM_W = 63;   // dividend width of the normal division

   typedef logic signed [31:0] coord_type;

   // carried alongside the length square root
   typedef struct packed {
      logic [2:0][30:0] rmag;
      logic [2:0]       rneg;
      logic signed [7:0] shift;
      logic             deg;
      logic [2:0][31:0] ctr;
   } len_side_type;

   // carried alongside the normal division
   typedef struct packed {
      logic [2:0]       rneg;
      logic [47:0]      area;
      logic             deg;
      logic [2:0][31:0] ctr;
   } div_side_type;

   // carried to the output once the normal is known
   typedef struct packed {
      logic [2:0][31:0] n;
      logic [47:0]      area;
      logic             deg;
      logic [2:0][31:0] ctr;
   } res_side_type;

   function automatic logic [6:0] bitlen65(input logic [64:0] v);
      logic [6:0] n;
      begin
         n = '0;
         for (int i = 0; i < 65; i++) begin
            if (v[i]) n = 7'(i + 1);
         end
         return n;
      end
   endfunction

   // -------------------------------------------------------------------------
   // global advance: the pipe moves unless a finished response is held
   // -------------------------------------------------------------------------
   logic rsp_valid_ff;
   logic en;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   coord_type va [3];
   coord_type vb [3];
   coord_type vc [3];

   assign va[0] = req_vert_a_x;
   assign va[1] = req_vert_a_y;
   assign va[2] = req_vert_a_z;
   assign vb[0] = req_vert_b_x;
   assign vb[1] = req_vert_b_y;
   assign vb[2] = req_vert_b_z;
   assign vc[0] = req_vert_c_x;
   assign vc[1] = req_vert_c_y;
   assign vc[2] = req_vert_c_z;

   // -------------------------------------------------------------------------
   // front stages a1..a8
   // -------------------------------------------------------------------------
   logic [7:0] a_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= '0;
      end else if (en) begin
         a_v_ff <= {a_v_ff[6:0], req_valid};
      end
   end

   // a1: edges AB, AC and vertex sums
   logic signed [32:0] e1_ff  [3];
   logic signed [32:0] e2_ff  [3];
   logic signed [33:0] sum_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i]  <= 33'(vb[i]) - 33'(va[i]);
            e2_ff[i]  <= 33'(vc[i]) - 33'(va[i]);
            sum_ff[i] <= 34'(va[i]) + 34'(vb[i]) + 34'(vc[i]);
         end
      end
   end

   // a2: cross-product partial products; centroid magnitude times 1/3
   logic signed [65:0] pp_ff   [3];
   logic signed [65:0] pq_ff   [3];
   logic [51:0]        plo_ff  [3];
   logic [51:0]        phi_ff  [3];
   logic [2:0]         sneg_ff;
   logic [33:0]        cmag    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cmag[i] = 34'((sum_ff[i] < 0) ? -sum_ff[i] : sum_ff[i]) + 34'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff[0] <= e2_ff[1] * e1_ff[2];
         pq_ff[0] <= e2_ff[2] * e1_ff[1];
         pp_ff[1] <= e2_ff[2] * e1_ff[0];
         pq_ff[1] <= e2_ff[0] * e1_ff[2];
         pp_ff[2] <= e2_ff[0] * e1_ff[1];
         pq_ff[2] <= e2_ff[1] * e1_ff[0];
         for (int i = 0; i < 3; i++) begin
            plo_ff[i]  <= 52'(cmag[i][16:0]) * 52'(RECIP3);
            phi_ff[i]  <= 52'(cmag[i][33:17]) * 52'(RECIP3);
            sneg_ff[i] <= sum_ff[i] < 0;
         end
      end
   end

   // a3: exact cross product, centroid rounded to nearest
   logic signed [66:0] w_ff    [3];
   logic [31:0]        ctr3_ff [3];
   logic [68:0]        ctot    [3];
   logic [31:0]        cquo    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ctot[i] = {phi_ff[i], 17'b0} + 69'(plo_ff[i]);
         cquo[i] = ctot[i][67:36];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            w_ff[i]    <= 67'(pp_ff[i]) - 67'(pq_ff[i]);
            ctr3_ff[i] <= sneg_ff[i] ? -cquo[i] : cquo[i];
         end
      end
   end

   // a4: magnitudes and their union for the bit length
   logic [64:0]        mag_ff  [3];
   logic [2:0]         neg4_ff;
   logic [64:0]        ormag_ff;
   logic [31:0]        ctr4_ff [3];
   logic signed [66:0] wabs    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wabs[i] = (w_ff[i] < 0) ? -w_ff[i] : w_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= wabs[i][64:0];
            neg4_ff[i] <= w_ff[i] < 0;
            ctr4_ff[i] <= ctr3_ff[i];
         end
         ormag_ff <= wabs[0][64:0] | wabs[1][64:0] | wabs[2][64:0];
      end
   end

   // a5: bit length of the largest component
   logic [6:0]  bl_ff;
   logic [64:0] mag5_ff [3];
   logic [2:0]  neg5_ff;
   logic [31:0] ctr5_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         bl_ff   <= bitlen65(ormag_ff);
         mag5_ff <= mag_ff;
         neg5_ff <= neg4_ff;
         ctr5_ff <= ctr4_ff;
      end
   end

   // a6: block scaling so the largest magnitude lies in [2^30, 2^31)
   len_side_type      side6;
   len_side_type      side6_ff;
   logic signed [7:0] sh6;
   logic [64:0]       scaled [3];

   always_comb begin
      sh6 = $signed({1'b0, bl_ff}) - 8'sd31;
      for (int i = 0; i < 3; i++) begin
         if (sh6 > 8'sd0) begin
            scaled[i] = mag5_ff[i] >> sh6[6:0];
         end else begin
            scaled[i] = mag5_ff[i] << 7'(-sh6);
         end
         side6.rmag[i] = scaled[i][30:0];
         side6.ctr[i]  = ctr5_ff[i];
      end
      side6.rneg  = neg5_ff;
      side6.shift = sh6;
      side6.deg   = (bl_ff == 7'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side6_ff <= side6;
      end
   end

   // a7: squares; a8: squared length
   logic [61:0]  sq7_ff [3];
   len_side_type side7_ff;
   logic [63:0]  l2_ff;
   len_side_type side8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq7_ff[i] <= 62'(side6_ff.rmag[i]) * 62'(side6_ff.rmag[i]);
         end
         side7_ff <= side6_ff;
         l2_ff    <= 64'(sq7_ff[0]) + 64'(sq7_ff[1]) + 64'(sq7_ff[2]);
         side8_ff <= side7_ff;
      end
   end

   // -------------------------------------------------------------------------
   // length square root
   // -------------------------------------------------------------------------
   logic [SQRT_LEN_W-1:0] len_root;
   logic [SQRT_LEN_W-1:0] sq_v_ff;
   len_side_type          sq_side_ff [SQRT_LEN_W];

   tfg_isqrt #(
      .IN_W   (64),
      .ROOT_W (SQRT_LEN_W)
   ) u_len_sqrt (
      .clock (clock),
      .en    (en),
      .value (l2_ff),
      .root  (len_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
      end else if (en) begin
         sq_v_ff <= {sq_v_ff[SQRT_LEN_W-2:0], a_v_ff[7]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0] <= side8_ff;
         for (int k = 1; k < SQRT_LEN_W; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // -------------------------------------------------------------------------
   // b1: dividends with half-divisor rounding, area from the length
   // -------------------------------------------------------------------------
   len_side_type sd;
   logic [NUM_W-1:0] num_b [3];
   logic [48:0]      area_big;
   logic [47:0]      area_b;
   logic [5:0]       area_rsh;
   div_side_type     bside;

   always_comb begin
      sd       = sq_side_ff[SQRT_LEN_W-1];
      area_big = '0;
      area_rsh = '0;
      for (int i = 0; i < 3; i++) begin
         num_b[i] = (NUM_W'(sd.rmag[i]) << 30) + NUM_W'(len_root >> 1);
      end
      if (sd.shift >= 8'sd17) begin
         area_big = 49'(len_root) << 5'(sd.shift - 8'sd17);
         area_b   = (area_big > 49'(AREA_MAX)) ? AREA_MAX : area_big[47:0];
      end else begin
         area_rsh = 6'(8'sd17 - sd.shift);
         area_big = (49'(len_root) + (49'd1 << (area_rsh - 6'd1))) >> area_rsh;
         area_b   = area_big[47:0];
      end
      bside.rneg = sd.rneg;
      bside.area = area_b;
      bside.deg  = sd.deg;
      bside.ctr  = sd.ctr;
   end

   logic             b_v_ff;
   logic [NUM_W-1:0] num_b_ff [3];
   logic [31:0]      den_b_ff;
   div_side_type     bside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= sq_v_ff[SQRT_LEN_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_b_ff <= num_b;
         den_b_ff <= len_root;
         bside_ff <= bside;
      end
   end

   // -------------------------------------------------------------------------
   // restoring division, one quotient bit per stage, three lanes
   // -------------------------------------------------------------------------
   logic [NUM_W-1:0]     dr_ff   [DIV_STEPS][3];
   logic [31:0]          dden_ff [DIV_STEPS];
   logic [30:0]          dq_ff   [DIV_STEPS][3];
   div_side_type         dside_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] dv_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      localparam int B = DIV_STEPS - 1 - k;
      logic [NUM_W-1:0] r_prev [3];
      logic [NUM_W-1:0] r_in   [3];
      logic [30:0]      q_prev [3];
      logic [30:0]      q_in   [3];
      logic [31:0]      den_prev;
      div_side_type     side_prev;
      logic [NUM_W-1:0] trial;

      if (k == 0) begin : g_first
         assign r_prev    = num_b_ff;
         assign q_prev    = '{default: '0};
         assign den_prev  = den_b_ff;
         assign side_prev = bside_ff;
      end else begin : g_next
         assign r_prev    = dr_ff[k-1];
         assign q_prev    = dq_ff[k-1];
         assign den_prev  = dden_ff[k-1];
         assign side_prev = dside_ff[k-1];
      end

      always_comb begin
         trial = NUM_W'(den_prev) << B;
         for (int i = 0; i < 3; i++) begin
            r_in[i] = r_prev[i];
            q_in[i] = q_prev[i];
            if (r_prev[i] >= trial) begin
               r_in[i]    = r_prev[i] - trial;
               q_in[i][B] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dr_ff[k]    <= r_in;
            dq_ff[k]    <= q_in;
            dden_ff[k]  <= den_prev;
            dside_ff[k] <= side_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (en) begin
         dv_ff <= {dv_ff[DIV_STEPS-2:0], b_v_ff};
      end
   end

   // -------------------------------------------------------------------------
   // c1..c4: centroid dot product, outward flip, horizontal squared length
   // -------------------------------------------------------------------------
   div_side_type dq_side;
   coord_type    n_raw [3];
   res_side_type c1_side;

   always_comb begin
      dq_side = dside_ff[DIV_STEPS-1];
      for (int i = 0; i < 3; i++) begin
         n_raw[i] = dq_side.rneg[i] ? -$signed({1'b0, dq_ff[DIV_STEPS-1][i]})
                                    :  $signed({1'b0, dq_ff[DIV_STEPS-1][i]});
         c1_side.n[i] = n_raw[i];
      end
      c1_side.area = dq_side.area;
      c1_side.deg  = dq_side.deg;
      c1_side.ctr  = dq_side.ctr;
   end

   logic [3:0]         c_v_ff;
   logic signed [63:0] dotp_ff [3];
   res_side_type       c1_side_ff, c2_side_ff, c3_side_ff, c4_side_ff;
   logic signed [65:0] dot;
   res_side_type       c2_side;
   logic signed [63:0] sqx, sqy;
   logic [63:0]        sqx_ff, sqy_ff;
   logic [61:0]        xy2_ff;

   always_comb begin
      dot     = 66'(dotp_ff[0]) + 66'(dotp_ff[1]) + 66'(dotp_ff[2]);
      c2_side = c1_side_ff;
      if (dot < 0) begin
         for (int i = 0; i < 3; i++) begin
            c2_side.n[i] = -c1_side_ff.n[i];
         end
      end
      sqx = $signed(c2_side_ff.n[0]) * $signed(c2_side_ff.n[0]);
      sqy = $signed(c2_side_ff.n[1]) * $signed(c2_side_ff.n[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= '0;
      end else if (en) begin
         c_v_ff <= {c_v_ff[2:0], dv_ff[DIV_STEPS-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dotp_ff[i] <= $signed(dq_side.ctr[i]) * n_raw[i];
         end
         c1_side_ff <= c1_side;
         c2_side_ff <= c2_side;
         sqx_ff     <= sqx;
         sqy_ff     <= sqy;
         c3_side_ff <= c2_side_ff;
         xy2_ff     <= 62'(sqx_ff) + 62'(sqy_ff);
         c4_side_ff <= c3_side_ff;
      end
   end

   // -------------------------------------------------------------------------
   // horizontal length sqrt, then both angle units side by side
   // -------------------------------------------------------------------------
   logic [SQRT_XY_W-1:0] xy_root;
   logic [SQRT_XY_W-1:0] t_v_ff;
   res_side_type         t_side_ff [SQRT_XY_W];

   tfg_isqrt #(
      .IN_W   (62),
      .ROOT_W (SQRT_XY_W)
   ) u_xy_sqrt (
      .clock (clock),
      .en    (en),
      .value (xy2_ff),
      .root  (xy_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         t_v_ff <= '0;
      end else if (en) begin
         t_v_ff <= {t_v_ff[SQRT_XY_W-2:0], c_v_ff[3]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_side_ff[0] <= c4_side_ff;
         for (int k = 1; k < SQRT_XY_W; k++) begin
            t_side_ff[k] <= t_side_ff[k-1];
         end
      end
   end

   res_side_type               t_side;
   logic signed [ANGLE_W-1:0]  elev_raw, azim_raw;

   assign t_side = t_side_ff[SQRT_XY_W-1];

   tfg_cordic u_elev (
      .clock (clock),
      .en    (en),
      .y_in  ($signed(t_side.n[2])),
      .x_in  ($signed({1'b0, xy_root})),
      .angle (elev_raw)
   );

   tfg_cordic u_azim (
      .clock (clock),
      .en    (en),
      .y_in  ($signed(t_side.n[0])),
      .x_in  ($signed(t_side.n[1])),
      .angle (azim_raw)
   );

   logic [CORDIC_LAT-1:0] k_v_ff;
   res_side_type          k_side_ff [CORDIC_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= '0;
      end else if (en) begin
         k_v_ff <= {k_v_ff[CORDIC_LAT-2:0], t_v_ff[SQRT_XY_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_side_ff[0] <= t_side;
         for (int k = 1; k < CORDIC_LAT; k++) begin
            k_side_ff[k] <= k_side_ff[k-1];
         end
      end
   end

   // -------------------------------------------------------------------------
   // output: clamp elevation, wrap azimuth, zero area, normal and angles on degenerate
   // -------------------------------------------------------------------------
   res_side_type              ks;
   logic signed [ANGLE_W-1:0] elev_c, azim_c;

   always_comb begin
      ks     = k_side_ff[CORDIC_LAT-1];
      elev_c = elev_raw;
      if (elev_raw > HALF_PI_Q28) elev_c = HALF_PI_Q28;
      if (elev_raw < -HALF_PI_Q28) elev_c = -HALF_PI_Q28;
      azim_c = azim_raw;
      if (azim_c < 0) azim_c = azim_c + TWO_PI_Q28;
      if (azim_c >= TWO_PI_Q28) azim_c = azim_c - TWO_PI_Q28;
      if (azim_c < 0) azim_c = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= k_v_ff[CORDIC_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_centre_x   <= $signed(ks.ctr[0]);
         rsp_centre_y   <= $signed(ks.ctr[1]);
         rsp_centre_z   <= $signed(ks.ctr[2]);
         rsp_degenerate <= ks.deg;
         if (ks.deg) begin
            rsp_facet_area <= '0;
            rsp_unit_nx    <= '0;
            rsp_unit_ny    <= '0;
            rsp_unit_nz    <= '0;
            rsp_elevation  <= '0;
            rsp_azimuth    <= '0;
         end else begin
            rsp_facet_area <= ks.area;
            rsp_unit_nx    <= $signed(ks.n[0]);
            rsp_unit_ny    <= $signed(ks.n[1]);
            rsp_unit_nz    <= $signed(ks.n[2]);
            rsp_elevation  <= elev_c[29:0];
            rsp_azimuth    <= azim_c[30:0];
         end
      end
   end

   // -------------------------------------------------------------------------
   // checks
   // -------------------------------------------------------------------------
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_unit_nx == 32'sd0 && rsp_unit_ny == 32'sd0
         && rsp_unit_nz == 32'sd0 && rsp_facet_area == 48'd0 && rsp_azimuth == 31'd0)
      else $error("degenerate response carries a nonzero normal or area");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_unit_nx <= 32'sd1073741824 && rsp_unit_nx >= -32'sd1073741824
         && rsp_unit_ny <= 32'sd1073741824 && rsp_unit_ny >= -32'sd1073741824
         && rsp_unit_nz <= 32'sd1073741824 && rsp_unit_nz >= -32'sd1073741824)
      else $error("normal component exceeds unit range");

   a_azim_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_azimuth < 31'(TWO_PI_Q28))
      else $error("azimuth not wrapped below two pi");

   a_elev_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_elevation <= 30'sd421657428 && rsp_elevation >= -30'sd421657428)
      else $error("elevation outside half pi");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(k_v_ff) && $stable(dv_ff) && $stable(sq_v_ff))
      else $error("pipeline moved while the response was held");

endmodule
`default_nettype wire

>>> sim/tb_triangle_facet_geometry.sv
// Testbench for triangle_facet_geometry: directed and random triangles checked against a predictor.
`default_nettype none
module tb_triangle_facet_geometry;
   timeunit 1ns;
   timeprecision 1ps;
   import tfg_pkg::*;

   localparam int LATENCY   = 138;
   localparam int IDLE_LIMIT = 20000;   // cycles with no handshake before giving up

   typedef struct packed {
      logic signed [31:0] cx, cy, cz;
      logic [47:0]        area;
      logic signed [31:0] nx, ny, nz;
      logic signed [29:0] elev;
      logic [30:0]        azim;
      logic               degen;
   } facet_type;

   // 65-bit magnitude with sign, as a signed 67-bit value
   typedef logic signed [66:0] wide_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] vert [9];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   facet_type got;

   facet_type facet_queue [$];
   int     n_errors = 0;
   int     send_idle_pct = 0;   // percent of cycles the sender holds off
   int     stall_pct = 0;       // percent of cycles the receiver stalls
   int     idle_cycles = 0;

   triangle_facet_geometry i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vert_a_x(vert[0]), .req_vert_a_y(vert[1]), .req_vert_a_z(vert[2]),
      .req_vert_b_x(vert[3]), .req_vert_b_y(vert[4]), .req_vert_b_z(vert[5]),
      .req_vert_c_x(vert[6]), .req_vert_c_y(vert[7]), .req_vert_c_z(vert[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_centre_x(got.cx), .rsp_centre_y(got.cy), .rsp_centre_z(got.cz),
      .rsp_facet_area(got.area),
      .rsp_unit_nx(got.nx), .rsp_unit_ny(got.ny), .rsp_unit_nz(got.nz),
      .rsp_elevation(got.elev), .rsp_azimuth(got.azim),
      .rsp_degenerate(got.degen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;   // arithmetic shift floors
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (y == 0) return (x < 0) ? longint'(PI_Q28) : 0;
      if (x == 0) return (y > 0) ? longint'(HALF_PI_Q28) : -longint'(HALF_PI_Q28);
      if (x < 0) begin
         z = (y > 0) ? longint'(PI_Q28) : -longint'(PI_Q28);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_q28(i));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_q28(i));
         end
      end
      return z;
   endfunction

   function automatic longint third_rounded(longint s);
      longint q;
      q = ((s < 0 ? -s : s) + 1) / 3;
      return (s < 0) ? -q : q;
   endfunction

   function automatic facet_type predict_facet(logic signed [31:0] v [9]);
      facet_type f;
      longint e1 [3], e2 [3], ctr [3], r [3], n [3];
      wide_type  w [3];
      wide_type  mag;
      int     bl, sh, b;
      longint unsigned l2, len, q, mr, area;
      longint dot, elev, azim;
      f = '0;
      for (int i = 0; i < 3; i++) begin
         ctr[i] = third_rounded(longint'(v[i]) + longint'(v[3+i]) + longint'(v[6+i]));
         e1[i] = longint'(v[3+i]) - longint'(v[i]);
         e2[i] = longint'(v[6+i]) - longint'(v[i]);
      end
      w[0] = wide_type'(e2[1]) * wide_type'(e1[2]) - wide_type'(e2[2]) * wide_type'(e1[1]);
      w[1] = wide_type'(e2[2]) * wide_type'(e1[0]) - wide_type'(e2[0]) * wide_type'(e1[2]);
      w[2] = wide_type'(e2[0]) * wide_type'(e1[1]) - wide_type'(e2[1]) * wide_type'(e1[0]);
      bl = 0;
      for (int i = 0; i < 3; i++) begin
         mag = (w[i] < 0) ? -w[i] : w[i];
         b = 0;
         for (int k = 0; k < 67; k++) if (mag[k]) b = k + 1;
         if (b > bl) bl = b;
      end
      f.cx = ctr[0][31:0];
      f.cy = ctr[1][31:0];
      f.cz = ctr[2][31:0];
      if (bl == 0) begin
         f.degen = 1'b1;
         return f;
      end
      sh = bl - 31;
      l2 = 0;
      for (int i = 0; i < 3; i++) begin
         mag = (w[i] < 0) ? -w[i] : w[i];
         mag = (sh > 0) ? (mag >> sh) : (mag << -sh);   // magnitude truncates
         r[i] = (w[i] < 0) ? -longint'(mag) : longint'(mag);
         mr = longint'(mag);
         l2 += mr * mr;
      end
      len = int_sqrt(l2);
      for (int i = 0; i < 3; i++) begin
         mr = (r[i] < 0) ? -r[i] : r[i];
         q = ((mr << 30) + len / 2) / len;
         n[i] = (r[i] < 0) ? -longint'(q) : longint'(q);
      end
      if (sh >= 17) begin
         // len < 2^32 and the shift is at most 17, so nothing wraps
         area = len << (sh - 17);
         if (area > AREA_MAX) area = AREA_MAX;
      end else begin
         area = (len + (64'd1 << (16 - sh))) >> (17 - sh);
      end
      dot = 0;
      for (int i = 0; i < 3; i++) dot += n[i] * ctr[i];
      if (dot < 0) for (int i = 0; i < 3; i++) n[i] = -n[i];
      elev = vector_angle(n[2], longint'(int_sqrt(n[0]*n[0] + n[1]*n[1])));
      if (elev > longint'(HALF_PI_Q28)) elev = HALF_PI_Q28;
      if (elev < -longint'(HALF_PI_Q28)) elev = -longint'(HALF_PI_Q28);
      azim = vector_angle(n[0], n[1]);
      if (azim < 0) azim += longint'(TWO_PI_Q28);
      if (azim >= longint'(TWO_PI_Q28)) azim -= longint'(TWO_PI_Q28);
      if (azim < 0) azim = 0;
      f.area = area[47:0];
      f.nx = n[0][31:0];
      f.ny = n[1][31:0];
      f.nz = n[2][31:0];
      f.elev = elev[29:0];
      f.azim = azim[30:0];
      return f;
   endfunction

   // ---------------- request driver ----------------

   // Sends one triangle; holds off at random first, then waits for acceptance.
   // Valid stays high afterwards so back-to-back requests leave no gap.
   task automatic send_facet(input logic signed [31:0] v [9]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      foreach (v[i]) vert[i] <= v[i];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      facet_queue.push_back(predict_facet(v));
   endtask

   // Random stall pattern on the response side, driven at the edge.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Response checker: compares each accepted response with the oldest prediction.
   always @(posedge clock) begin
      facet_type exp_f;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (facet_queue.size() == 0) begin
            $display("%0t unexpected response %h", $realtime, got);
            n_errors++;
         end else begin
            exp_f = facet_queue.pop_front();
            if (got.cx !== exp_f.cx) begin
               $display("%0t centre_x exp %0d got %0d", $realtime, exp_f.cx, got.cx);
               n_errors++;
            end
            if (got.cy !== exp_f.cy) begin
               $display("%0t centre_y exp %0d got %0d", $realtime, exp_f.cy, got.cy);
               n_errors++;
            end
            if (got.cz !== exp_f.cz) begin
               $display("%0t centre_z exp %0d got %0d", $realtime, exp_f.cz, got.cz);
               n_errors++;
            end
            if (got.area !== exp_f.area) begin
               $display("%0t facet_area exp %0d got %0d", $realtime, exp_f.area, got.area);
               n_errors++;
            end
            if (got.nx !== exp_f.nx) begin
               $display("%0t unit_nx exp %0d got %0d", $realtime, exp_f.nx, got.nx);
               n_errors++;
            end
            if (got.ny !== exp_f.ny) begin
               $display("%0t unit_ny exp %0d got %0d", $realtime, exp_f.ny, got.ny);
               n_errors++;
            end
            if (got.nz !== exp_f.nz) begin
               $display("%0t unit_nz exp %0d got %0d", $realtime, exp_f.nz, got.nz);
               n_errors++;
            end
            if (got.elev !== exp_f.elev) begin
               $display("%0t elevation exp %0d got %0d", $realtime, exp_f.elev, got.elev);
               n_errors++;
            end
            if (got.azim !== exp_f.azim) begin
               $display("%0t azimuth exp %0d got %0d", $realtime, exp_f.azim, got.azim);
               n_errors++;
            end
            if (got.degen !== exp_f.degen) begin
               $display("%0t degenerate exp %0b got %0b", $realtime, exp_f.degen, got.degen);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: counts cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   // Coordinate with a random magnitude class so that small, mid and full-range
   // triangles all occur.
   function automatic logic signed [31:0] rand_coord(int cls);
      case (cls)
         0: return $signed($urandom_range(8191)) - 4096;
         1: return $signed($urandom) >>> $urandom_range(31);
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (facet_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic signed [31:0] v [9];
      logic signed [31:0] mn, mx;
      mn = 32'sh8000_0000;
      mx = 32'sh7fff_ffff;
      // all-zero triangle: degenerate with zero centroid
      foreach (v[i]) v[i] = 0;
      send_facet(v);
      // collinear points: degenerate, centroid still given
      v = '{0, 0, 0, 32'sh10000, 32'sh20000, 32'sh30000, 32'sh20000, 32'sh40000, 32'sh60000};
      send_facet(v);
      // unit right triangle in each plane: axis normals, axis-aligned angles
      v = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
      send_facet(v);
      v = '{0, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
      send_facet(v);
      v = '{0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
      send_facet(v);
      // reversed winding, off origin: normal flip by centroid
      v = '{0, 0, 32'sh50000, 0, 32'sh10000, 32'sh50000, 32'sh10000, 0, 32'sh50000};
      send_facet(v);
      v = '{32'sh30000, 0, 0, 32'sh30000, 0, 32'sh10000, 32'sh30000, 32'sh10000, 0};
      send_facet(v);
      v = '{0, -32'sh40000, 0, 32'sh10000, -32'sh40000, 0, 0, -32'sh40000, 32'sh10000};
      send_facet(v);
      // centroid at origin: zero dot, no flip
      v = '{32'sh10000, 0, 0, -32'sh10000, 32'sh10000, 0, 0, -32'sh10000, 0};
      send_facet(v);
      // tiny triangle: LSB-sized edges, area rounding
      v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      send_facet(v);
      v = '{5, 7, -3, 6, 7, -3, 5, 9, -2};
      send_facet(v);
      // extremes: full range coordinates, area saturation
      v = '{mn, mn, mn, mx, mn, mx, mn, mx, mx};
      send_facet(v);
      v = '{mx, mx, mx, mn, mx, mn, mx, mn, mn};
      send_facet(v);
      v = '{mn, mn, 0, mx, mn, 0, mn, mx, 0};
      send_facet(v);
      v = '{mx, 0, mn, mn, mx, 0, 0, mn, mx};
      send_facet(v);
      v = '{mn, mn, mn, mn, mn, mn, mx, mx, mx};
      send_facet(v);
      v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
      send_facet(v);
      // negative centroid rounding
      v = '{-1, -2, -4, -1, -1, 0, 0, -1, -1};
      send_facet(v);
      // diagonal normal, azimuth near wrap
      v = '{0, 0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 0, 32'sh10000};
      send_facet(v);
      v = '{32'sh10000, -32'sh1, 0, 32'sh20000, -32'sh1, 0, 32'sh10000, -32'sh1, 32'sh10000};
      send_facet(v);
      wait_drained();   // sender pauses until all responses are in
   endtask

   task automatic test_random(input int count);
      logic signed [31:0] v [9];
      int cls, kind;
      for (int k = 0; k < count; k++) begin
         cls = $urandom_range(2);
         kind = $urandom_range(19);
         foreach (v[i]) v[i] = rand_coord(cls);
         if (kind == 0) begin
            v[3] = v[0]; v[4] = v[1]; v[5] = v[2];            // repeated vertex
         end else if (kind == 1) begin
            for (int i = 0; i < 3; i++) v[6+i] = v[i] + 2 * (v[3+i] - v[i]);   // collinear
         end else if (kind == 2) begin
            v[2] = v[5]; v[8] = v[5];                          // flat in z
         end
         send_facet(v);
      end
   endtask

   initial begin
      foreach (vert[i]) vert[i] <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 0;  stall_pct = 0;  test_random(350);
      send_idle_pct = 78; stall_pct = 0;  test_random(350);
      send_idle_pct = 0;  stall_pct = 78; test_random(350);
      send_idle_pct = 10; stall_pct = 10; test_random(350);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (n_errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
